FILE: design/hfcr_pkg.sv
`default_nettype none

package hfcr_pkg;

   // payload length limit and field widths
   localparam int HFCR_MAX_PAYLOAD = 16;
   localparam int BYTE_W           = 8;
   localparam int LEN_W            = 5;
   localparam int CSR_INDEX_W      = 2;

   // queue between the framer and the command stage
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // frame terminator
   localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;

   // command bit positions
   localparam int CMD_POWER_OFF_BIT = 0;
   localparam int CMD_SHUTDOWN_BIT  = 1;
   localparam int CMD_DISARM_BIT    = 2;
   localparam int CMD_RESET_BIT     = 3;
   localparam int CMD_ARM_BIT       = 4;
   localparam int CMD_CHASSIS_BIT   = 5;

   // register reset values
   localparam logic [BYTE_W-1:0] FIRST_HEADER_RESET   = 8'h00;
   localparam logic [BYTE_W-1:0] SECOND_HEADER_RESET  = 8'h00;
   localparam logic [LEN_W-1:0]  PAYLOAD_LENGTH_RESET = 5'd2;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_HEADER   = 2'd0,
      CSR_SECOND_HEADER  = 2'd1,
      CSR_PAYLOAD_LENGTH = 2'd2
   } csr_index_type;

   // framer phase
   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_SECOND  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   // configuration seen by the framer
   typedef struct packed {
      logic [BYTE_W-1:0] first_header;
      logic [BYTE_W-1:0] second_header;
      logic [LEN_W-1:0]  payload_length;
   } cfg_type;

   // per-byte classification passed from framer to command stage
   typedef struct packed {
      logic              frame_end;
      logic              frame_ok;
      logic [BYTE_W-1:0] command;
   } event_type;

endpackage

`default_nettype wire

FILE: design/hfcr_front.sv
`default_nettype none

module hfcr_front #(
   parameter int MAX_PAYLOAD = hfcr_pkg::HFCR_MAX_PAYLOAD
) (
   input  wire                            clock,
   input  wire                            reset,
   input  hfcr_pkg::cfg_type              cfg,
   input  wire                            byte_valid,
   input  wire  [hfcr_pkg::BYTE_W-1:0]    byte_data,
   output hfcr_pkg::event_type            event_out
);
   import hfcr_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int LW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]  held_ff, held_in;

   logic [LW-1:0]      len_ext;
   logic [LW-1:0]      eff_len;
   logic [LW-1:0]      count_next;
   logic               at_end;

   // effective length: zero acts as one, clamp at the limit
   always_comb begin
      len_ext = LW'(cfg.payload_length);
      if (len_ext == '0) begin
         eff_len = LW'(1);
      end else if (len_ext > LW'(MAX_PAYLOAD)) begin
         eff_len = LW'(MAX_PAYLOAD);
      end else begin
         eff_len = len_ext;
      end
      count_next = LW'(count_ff) + LW'(1);
      at_end     = (count_next >= eff_len);
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      held_in  = held_ff;
      if (byte_valid) begin
         case (phase_ff)
            PH_SECOND: begin
               if (byte_data == cfg.second_header) begin
                  phase_in = PH_PAYLOAD;
                  count_in = '0;
               end else if (byte_data == cfg.first_header) begin
                  phase_in = PH_SECOND;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_PAYLOAD: begin
               if (count_ff == '0) begin
                  held_in = byte_data;
               end
               if (at_end) begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end else begin
                  count_in = CNT_W'(count_next);
               end
            end
            default: begin
               phase_in = (byte_data == cfg.first_header) ? PH_SECOND : PH_HUNT;
            end
         endcase
      end
   end

   // classification of the current byte
   always_comb begin
      event_out = '0;
      if (phase_ff == PH_PAYLOAD && at_end) begin
         event_out.frame_end = 1'b1;
         event_out.frame_ok  = (byte_data == CR_BYTE);
         event_out.command   = (count_ff == '0) ? byte_data : held_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         held_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         held_ff  <= held_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/hfcr_queue.sv
`default_nettype none

module hfcr_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  hfcr_pkg::event_type   push_data,
   output logic                  full,
   input  wire                   pop,
   output logic                  not_empty,
   output hfcr_pkg::event_type   pop_data
);
   import hfcr_pkg::*;

   event_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0]  count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   // status
   assign full      = (count_ff == QUEUE_COUNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_COUNT_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: design/hfcr_back.sv
`default_nettype none

module hfcr_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          event_valid,
   input  hfcr_pkg::event_type          event_in,
   output logic                         event_take,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_frame_end,
   output logic                         rsp_frame_ok,
   output logic [hfcr_pkg::BYTE_W-1:0]  rsp_command_byte,
   output logic                         rsp_arm_enable,
   output logic                         rsp_chassis_enable,
   output logic                         rsp_power_off_pulse,
   output logic                         rsp_shutdown_pulse,
   output logic                         rsp_reset_request,
   output logic                         rsp_chassis_disarm,
   output logic                         rsp_red_led
);
   import hfcr_pkg::*;

   logic               valid_ff;
   logic               frame_end_ff, frame_end_in;
   logic               frame_ok_ff, frame_ok_in;
   logic [BYTE_W-1:0]  command_ff, command_in;
   logic               arm_ff, arm_in;
   logic               chassis_ff, chassis_in;
   logic               power_off_ff, power_off_in;
   logic               shutdown_ff, shutdown_in;
   logic               reset_req_ff, reset_req_in;
   logic               disarm_ff, disarm_in;
   logic               led_ff, led_in;
   logic               apply;

   // take a request whenever the output register is free or draining
   assign event_take = event_valid && (!valid_ff || !rsp_stall);
   assign apply      = event_in.frame_end && event_in.frame_ok;

   // command decode; latched fields hold unless a valid frame ends
   always_comb begin
      frame_end_in = event_in.frame_end;
      frame_ok_in  = event_in.frame_ok;
      power_off_in = apply && event_in.command[CMD_POWER_OFF_BIT];
      shutdown_in  = apply && event_in.command[CMD_SHUTDOWN_BIT];
      command_in   = command_ff;
      arm_in       = arm_ff;
      chassis_in   = chassis_ff;
      reset_req_in = reset_req_ff;
      disarm_in    = disarm_ff;
      led_in       = led_ff;
      if (apply) begin
         command_in   = event_in.command;
         arm_in       = event_in.command[CMD_ARM_BIT];
         chassis_in   = event_in.command[CMD_CHASSIS_BIT];
         reset_req_in = event_in.command[CMD_RESET_BIT];
         disarm_in    = event_in.command[CMD_DISARM_BIT];
         led_in       = !led_ff;
      end
   end

   // output register, also holding the latched command state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         frame_end_ff <= 1'b0;
         frame_ok_ff  <= 1'b0;
         command_ff   <= '0;
         arm_ff       <= 1'b0;
         chassis_ff   <= 1'b0;
         power_off_ff <= 1'b0;
         shutdown_ff  <= 1'b0;
         reset_req_ff <= 1'b0;
         disarm_ff    <= 1'b0;
         led_ff       <= 1'b0;
      end else if (event_take) begin
         valid_ff     <= 1'b1;
         frame_end_ff <= frame_end_in;
         frame_ok_ff  <= frame_ok_in;
         command_ff   <= command_in;
         arm_ff       <= arm_in;
         chassis_ff   <= chassis_in;
         power_off_ff <= power_off_in;
         shutdown_ff  <= shutdown_in;
         reset_req_ff <= reset_req_in;
         disarm_ff    <= disarm_in;
         led_ff       <= led_in;
      end else if (!rsp_stall) begin
         valid_ff     <= 1'b0;
      end
   end

   // result ports
   assign rsp_valid           = valid_ff;
   assign rsp_frame_end       = frame_end_ff;
   assign rsp_frame_ok        = frame_ok_ff;
   assign rsp_command_byte    = command_ff;
   assign rsp_arm_enable      = arm_ff;
   assign rsp_chassis_enable  = chassis_ff;
   assign rsp_power_off_pulse = power_off_ff;
   assign rsp_shutdown_pulse  = shutdown_ff;
   assign rsp_reset_request   = reset_req_ff;
   assign rsp_chassis_disarm  = disarm_ff;
   assign rsp_red_led         = led_ff;

endmodule

`default_nettype wire

FILE: design/header_framed_command_receiver_unit.sv
// Command deframer for a received serial byte stream.
// Request channel: one byte per request (req_valid / req_stall / req_rx_byte).
// Response channel: exactly one response per request, in order, carrying the
// frame end / frame ok flags, the latched command state, the power-off and
// shutdown pulses and the LED level (rsp_valid / rsp_stall / rsp_* fields).
// CSR port: csr_write_enable, csr_index and csr_write_data set the two header
// bytes and the payload length; writes are expected only while idle.
// Throughput is one byte per clock while the response is not stalled: the framer
// classifies a byte in the cycle it is accepted and pushes it into a two-entry
// queue; the command stage pops one entry per cycle into the output register.
// An accepted request is written into a queue entry and then into the output
// register, from which its response is presented.
// When the receiver stalls, the response holds and the queue fills; once the
// queue is full req_stall rises until an entry drains.
// Synchronous reset clears framing state, latched command state, the queue
// and the output register; headers reset to 0x00 and payload length to 2.
`default_nettype none

module header_framed_command_receiver_unit #(
   parameter int MAX_PAYLOAD = hfcr_pkg::HFCR_MAX_PAYLOAD
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_write_enable,
   input  wire  [hfcr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [hfcr_pkg::BYTE_W-1:0]       csr_write_data,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [hfcr_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_frame_end,
   output logic                              rsp_frame_ok,
   output logic [hfcr_pkg::BYTE_W-1:0]       rsp_command_byte,
   output logic                              rsp_arm_enable,
   output logic                              rsp_chassis_enable,
   output logic                              rsp_power_off_pulse,
   output logic                              rsp_shutdown_pulse,
   output logic                              rsp_reset_request,
   output logic                              rsp_chassis_disarm,
   output logic                              rsp_red_led
);
   import hfcr_pkg::*;

   cfg_type    cfg_ff;
   event_type  front_event;
   event_type  queue_event;
   logic       queue_full;
   logic       queue_not_empty;
   logic       back_take;
   logic       req_accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_header   <= FIRST_HEADER_RESET;
         cfg_ff.second_header  <= SECOND_HEADER_RESET;
         cfg_ff.payload_length <= PAYLOAD_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FIRST_HEADER:   cfg_ff.first_header   <= csr_write_data;
            CSR_SECOND_HEADER:  cfg_ff.second_header  <= csr_write_data;
            CSR_PAYLOAD_LENGTH: cfg_ff.payload_length <= csr_write_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // request handshake
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   // framer
   hfcr_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .byte_valid (req_accept),
      .byte_data  (req_rx_byte),
      .event_out  (front_event)
   );

   // decoupling queue
   hfcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_event),
      .full      (queue_full),
      .pop       (back_take),
      .not_empty (queue_not_empty),
      .pop_data  (queue_event)
   );

   // command stage and response register
   hfcr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .event_valid         (queue_not_empty),
      .event_in            (queue_event),
      .event_take          (back_take),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_command_byte    (rsp_command_byte),
      .rsp_arm_enable      (rsp_arm_enable),
      .rsp_chassis_enable  (rsp_chassis_enable),
      .rsp_power_off_pulse (rsp_power_off_pulse),
      .rsp_shutdown_pulse  (rsp_shutdown_pulse),
      .rsp_reset_request   (rsp_reset_request),
      .rsp_chassis_disarm  (rsp_chassis_disarm),
      .rsp_red_led         (rsp_red_led)
   );

endmodule

`default_nettype wire
